// ----- design/mf3_pkg.sv -----
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants of the 3x3 median filter: default sizes,
// configuration register indexes, command codes and result flags.
// ----------------------------------------------------------------------------
package mf3_pkg;

  // default sizes for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 16;

  // configuration port and register widths
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 13;
  localparam int ROW_W     = 13;

  // register values after reset
  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1920;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd1080;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // result buffer sizing
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // flags that travel with each result
  typedef struct packed {
    logic last_of_run;
    logic end_of_row;
    logic end_of_frame;
  } res_tag_t;

endpackage

// ----- design/mf3_if.sv -----
// ----------------------------------------------------------------------------
// mf3 channel interfaces
// Valid/ready channels of the median filter: pixel input, result output
// and configuration writes.
// ----------------------------------------------------------------------------
interface mf3_pix_if #(
  parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, command, pixel_value, input ready);
  modport sink   (input valid, command, pixel_value, output ready);
endinterface

interface mf3_res_if #(
  parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] median_value;
  logic                  last_of_run;
  logic                  end_of_row;
  logic                  end_of_frame;

  modport source (output valid, median_value, last_of_run, end_of_row, end_of_frame,
                  input ready);
  modport sink   (input valid, median_value, last_of_run, end_of_row, end_of_frame,
                  output ready);
endinterface

interface mf3_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mf3_pkg::CFG_IDX_W-1:0]  index;
  logic [mf3_pkg::CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/mf3_window.sv -----
// ----------------------------------------------------------------------------
// mf3_window
// Front end: configuration registers, row/column counters, the line memory
// holding the two previous rows, and the two-column window. Each accepted
// item reads its line entry, registers it with the stage 1 payload, then writes
// it back and emits up to two 3x3 neighbourhoods.
// ----------------------------------------------------------------------------
module mf3_window #(
  parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  mf3_pix_if.sink                        pix_i,
  mf3_cfg_if.sink                        cfg_i,
  output logic                           lane_a_valid_o,
  output mf3_pkg::res_tag_t              lane_a_tag_o,
  output logic [8:0][PIXEL_BITS-1:0]     lane_a_win_o,
  output logic                           lane_b_valid_o,
  output mf3_pkg::res_tag_t              lane_b_tag_o,
  output logic [8:0][PIXEL_BITS-1:0]     lane_b_win_o
);
  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = PIXEL_BITS;

  // configuration registers
  logic [CFG_W-1:0] width_q, height_q;

  // counters
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // item decode
  logic [CW-1:0]    wlast, x;
  logic [CFG_W-1:0] h_eff;
  logic             draining, end_row, take, item_ok;

  // stage 1 registers
  logic             s1_valid_q;
  logic             s1_cmd_q, s1_x0_q, s1_eor_q, s1_upsel_q, s1_res_q, s1_drain_q, s1_fwd_q;
  logic [CW-1:0]    s1_x_q;
  logic [PW-1:0]    s1_px_q;

  // line memory: {upper, middle}
  logic [2*PW-1:0]  line_mem [MAX_WIDTH];
  logic [2*PW-1:0]  rdata_q, wdata_q, wdata, line;
  logic             wr_en;

  // window columns, index 0 up, 1 mid, 2 low
  logic [2:0][PW-1:0] win_c_q, win_p_q, cur;
  logic [PW-1:0]      mid, upr;

  // config port never stalls
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
        REG_IMAGE_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // clamp width and height, locate the item in the row
  always_comb begin
    if (width_q == '0) begin
      wlast = '0;
    end else if (int'(width_q) > MAX_WIDTH) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else begin
      wlast = CW'(width_q - 1'b1);
    end
    h_eff    = (height_q == '0) ? CFG_W'(1) : height_q;
    draining = (row_q >= h_eff);
    x        = (col_q > wlast) ? wlast : col_q;
    end_row  = (x == wlast);
  end

  assign pix_i.ready = en_i;
  assign take        = pix_i.valid && pix_i.ready;
  // a command that does not match the phase is dropped
  assign item_ok     = take && (pix_i.command == (draining ? CMD_DRAIN : CMD_PIXEL));

  // next counter values
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (item_ok) begin
      if (end_row) begin
        col_d = '0;
        row_d = draining ? '0 : ROW_W'(row_q + 1'b1);
      end else begin
        col_d = CW'(col_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (en_i) begin
        s1_valid_q <= item_ok;
      end
    end
  end

  // stage 1 payload, with forwarding flag for a write to the same entry
  always_ff @(posedge clk_i) begin
    if (item_ok) begin
      s1_cmd_q   <= pix_i.command;
      s1_px_q    <= pix_i.pixel_value;
      s1_x_q     <= x;
      s1_x0_q    <= (x == '0);
      s1_eor_q   <= end_row;
      s1_upsel_q <= (row_q <= ROW_W'(1));
      s1_res_q   <= (row_q != '0);
      s1_drain_q <= draining;
      s1_fwd_q   <= wr_en && (s1_x_q == x);
    end
  end

  // read the line entry, write back the shifted column
  assign line  = s1_fwd_q ? wdata_q : rdata_q;
  assign mid   = line[PW-1:0];
  assign upr   = line[2*PW-1:PW];
  assign wr_en = en_i && s1_valid_q && (s1_cmd_q == CMD_PIXEL);
  assign wdata = {mid, s1_px_q};

  always_ff @(posedge clk_i) begin
    if (item_ok) begin
      rdata_q <= line_mem[x];
    end
    if (wr_en) begin
      line_mem[s1_x_q] <= wdata;
      wdata_q          <= wdata;
    end
  end

  // current column
  always_comb begin
    cur[0] = s1_upsel_q ? mid : upr;
    cur[1] = mid;
    cur[2] = (s1_cmd_q == CMD_DRAIN) ? mid : s1_px_q;
  end

  // window shift, first column replicates itself
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_c_q <= '0;
      win_p_q <= '0;
    end else if (en_i && s1_valid_q) begin
      win_c_q <= cur;
      win_p_q <= s1_x0_q ? cur : win_c_q;
    end
  end

  // neighbourhoods: rows top to bottom, columns left to right
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_a_win_o[i*3+0] = win_p_q[i];
      lane_a_win_o[i*3+1] = win_c_q[i];
      lane_a_win_o[i*3+2] = cur[i];
      lane_b_win_o[i*3+0] = s1_x0_q ? cur[i] : win_c_q[i];
      lane_b_win_o[i*3+1] = cur[i];
      lane_b_win_o[i*3+2] = cur[i];
    end
  end

  assign lane_a_valid_o            = s1_valid_q && s1_res_q && !s1_x0_q;
  assign lane_a_tag_o.last_of_run  = !s1_eor_q;
  assign lane_a_tag_o.end_of_row   = 1'b0;
  assign lane_a_tag_o.end_of_frame = 1'b0;

  assign lane_b_valid_o            = s1_valid_q && s1_res_q && s1_eor_q;
  assign lane_b_tag_o.last_of_run  = 1'b1;
  assign lane_b_tag_o.end_of_row   = 1'b1;
  assign lane_b_tag_o.end_of_frame = s1_drain_q;

endmodule

// ----- design/mf3_median.sv -----
// ----------------------------------------------------------------------------
// mf3_median
// Four-stage min/max exchange network for the median of nine pixels.
// Each stage drops the extremes of a shrinking candidate set.
// ----------------------------------------------------------------------------
module mf3_median #(
  parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  mf3_pkg::res_tag_t          tag_i,
  input  logic [8:0][PIXEL_BITS-1:0] win_i,
  output logic                       valid_o,
  output mf3_pkg::res_tag_t          tag_o,
  output logic [PIXEL_BITS-1:0]      median_o
);
  import mf3_pkg::*;

  localparam int PW = PIXEL_BITS;

  // compare-exchange, returns {max, min}
  function automatic logic [2*PW-1:0] cx(input logic [PW-1:0] lo, input logic [PW-1:0] hi);
    return (lo < hi) ? {hi, lo} : {lo, hi};
  endfunction

  logic [3:0]    vld_q;
  res_tag_t      tag_a_q, tag_b_q, tag_c_q, tag_d_q;
  logic [PW-1:0] sa_b_q, sa_c_q, sa_d_q, sa_e_q, sa_v6_q, sa_v7_q, sa_v8_q;
  logic [PW-1:0] sb_b_q, sb_c_q, sb_d_q, sb_v7_q, sb_v8_q;
  logic [PW-1:0] sc_b_q, sc_c_q, sc_v8_q;
  logic [PW-1:0] sd_q;
  logic [PW-1:0] na_b, na_c, na_d, na_e;
  logic [PW-1:0] nb_b, nb_c, nb_d;
  logic [PW-1:0] nc_b, nc_c;
  logic [PW-1:0] nd_b;

  // min/max of six: top and middle rows
  always_comb begin
    logic [PW-1:0] a, b, c, d, e, f;
    a = win_i[0]; b = win_i[1]; c = win_i[2];
    d = win_i[3]; e = win_i[4]; f = win_i[5];
    {d, a} = cx(a, d);
    {e, b} = cx(b, e);
    {f, c} = cx(c, f);
    {b, a} = cx(a, b);
    {c, a} = cx(a, c);
    {f, e} = cx(e, f);
    {f, d} = cx(d, f);
    na_b = b; na_c = c; na_d = d; na_e = e;
  end

  // min/max of five
  always_comb begin
    logic [PW-1:0] a, b, c, d, e;
    a = sa_v6_q; b = sa_b_q; c = sa_c_q; d = sa_d_q; e = sa_e_q;
    {b, a} = cx(a, b);
    {d, c} = cx(c, d);
    {c, a} = cx(a, c);
    {e, a} = cx(a, e);
    {e, d} = cx(d, e);
    {e, b} = cx(b, e);
    nb_b = b; nb_c = c; nb_d = d;
  end

  // min/max of four
  always_comb begin
    logic [PW-1:0] a, b, c, d;
    a = sb_v7_q; b = sb_b_q; c = sb_c_q; d = sb_d_q;
    {b, a} = cx(a, b);
    {d, c} = cx(c, d);
    {c, a} = cx(a, c);
    {d, b} = cx(b, d);
    nc_b = b; nc_c = c;
  end

  // min/max of three, the middle one is the median
  always_comb begin
    logic [PW-1:0] a, b, c;
    a = sc_v8_q; b = sc_b_q; c = sc_c_q;
    {c, b} = cx(b, c);
    {c, a} = cx(a, c);
    {b, a} = cx(a, b);
    nd_b = b;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_a_q <= tag_i;
      sa_b_q  <= na_b;
      sa_c_q  <= na_c;
      sa_d_q  <= na_d;
      sa_e_q  <= na_e;
      sa_v6_q <= win_i[6];
      sa_v7_q <= win_i[7];
      sa_v8_q <= win_i[8];

      tag_b_q <= tag_a_q;
      sb_b_q  <= nb_b;
      sb_c_q  <= nb_c;
      sb_d_q  <= nb_d;
      sb_v7_q <= sa_v7_q;
      sb_v8_q <= sa_v8_q;

      tag_c_q <= tag_b_q;
      sc_b_q  <= nc_b;
      sc_c_q  <= nc_c;
      sc_v8_q <= sb_v8_q;

      tag_d_q <= tag_c_q;
      sd_q    <= nd_b;
    end
  end

  assign valid_o  = vld_q[3];
  assign tag_o    = tag_d_q;
  assign median_o = sd_q;

endmodule

// ----- design/mf3_out_buf.sv -----
// ----------------------------------------------------------------------------
// mf3_out_buf
// Small result queue that takes up to two results per cycle in order
// and hands one per transfer to the output channel.
// ----------------------------------------------------------------------------
module mf3_out_buf #(
  parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_a_i,
  input  mf3_pkg::res_tag_t     tag_a_i,
  input  logic [PIXEL_BITS-1:0] med_a_i,
  input  logic                  push_b_i,
  input  mf3_pkg::res_tag_t     tag_b_i,
  input  logic [PIXEL_BITS-1:0] med_b_i,
  output logic                  room_o,
  mf3_res_if.source             res_o
);
  import mf3_pkg::*;

  logic [PIXEL_BITS-1:0] med_q [OUT_DEPTH];
  res_tag_t              tag_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  wp_q, rp_q, wp1;
  logic [OUT_CNT_W-1:0]  cnt_q;
  logic                  pop;

  assign wp1    = OUT_PTR_W'(wp_q + 1'b1);
  assign pop    = res_o.valid && res_o.ready;
  // room for the two results one item can bring
  assign room_o = (cnt_q <= OUT_CNT_W'(OUT_DEPTH - 2));

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_a_i && push_b_i) begin
        wp_q <= OUT_PTR_W'(wp_q + 2'd2);
      end else if (push_a_i || push_b_i) begin
        wp_q <= wp1;
      end
      if (pop) begin
        rp_q <= OUT_PTR_W'(rp_q + 1'b1);
      end
      cnt_q <= OUT_CNT_W'(cnt_q + OUT_CNT_W'(push_a_i) + OUT_CNT_W'(push_b_i)
                          - OUT_CNT_W'(pop));
    end
  end

  // entry writes, lane a goes first
  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      med_q[wp_q] <= med_a_i;
      tag_q[wp_q] <= tag_a_i;
      if (push_b_i) begin
        med_q[wp1] <= med_b_i;
        tag_q[wp1] <= tag_b_i;
      end
    end else if (push_b_i) begin
      med_q[wp_q] <= med_b_i;
      tag_q[wp_q] <= tag_b_i;
    end
  end

  assign res_o.valid        = (cnt_q != '0);
  assign res_o.median_value = med_q[rp_q];
  assign res_o.last_of_run  = tag_q[rp_q].last_of_run;
  assign res_o.end_of_row   = tag_q[rp_q].end_of_row;
  assign res_o.end_of_frame = tag_q[rp_q].end_of_frame;

endmodule

// ----- design/median_filter_3x3.sv -----
// Path: a result is offered once its item has passed the line memory read and
//   window, the four exchange-network stages and the result queue.
// Throughput: one item per cycle unless the queue holds over two; a row's last
//   item gives two results, which the queue hands out one per output transfer.
// Reset: counters and window clear, width 1920 and height 1080; the line memory
//   is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter with border replication over a raster-order
// pixel stream, two line rows held in one synchronous memory.
// ----------------------------------------------------------------------------
module median_filter_3x3 #(
  parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mf3_pix_if.sink   pix_i,
  mf3_res_if.source res_o,
  mf3_cfg_if.sink   cfg_i
);
  import mf3_pkg::*;

  logic                        en;
  logic                        a_valid, b_valid, ma_valid, mb_valid;
  res_tag_t                    a_tag, b_tag, ma_tag, mb_tag;
  logic [8:0][PIXEL_BITS-1:0]  a_win, b_win;
  logic [PIXEL_BITS-1:0]       ma_med, mb_med;

  // front end: counters, line memory and window
  mf3_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .pix_i          (pix_i),
    .cfg_i          (cfg_i),
    .lane_a_valid_o (a_valid),
    .lane_a_tag_o   (a_tag),
    .lane_a_win_o   (a_win),
    .lane_b_valid_o (b_valid),
    .lane_b_tag_o   (b_tag),
    .lane_b_win_o   (b_win)
  );

  // lane a: result for the previous column
  mf3_median #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_median_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (a_valid),
    .tag_i    (a_tag),
    .win_i    (a_win),
    .valid_o  (ma_valid),
    .tag_o    (ma_tag),
    .median_o (ma_med)
  );

  // lane b: rightmost result of a row
  mf3_median #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_median_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (b_valid),
    .tag_i    (b_tag),
    .win_i    (b_win),
    .valid_o  (mb_valid),
    .tag_o    (mb_tag),
    .median_o (mb_med)
  );

  // result queue; the whole pipeline advances while it has room
  mf3_out_buf #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (en && ma_valid),
    .tag_a_i  (ma_tag),
    .med_a_i  (ma_med),
    .push_b_i (en && mb_valid),
    .tag_b_i  (mb_tag),
    .med_b_i  (mb_med),
    .room_o   (en),
    .res_o    (res_o)
  );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// median_filter_3x3 testbench
// Streams raster frames through the 3x3 median filter and checks every
// median and flag against a behavioral predictor. A short directed part
// covers pixel extremes, single-column rows, ignored commands and width
// cut mid-row. Oversized and zero register values follow, then random
// frames with mid-frame resizes. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import mf3_pkg::*;

  localparam int PIX_W         = PIXEL_BITS_DEF;
  localparam int MAX_W         = MAX_WIDTH_DEF;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int SETTLE_CYCLES = 10;
  localparam int NOISE_PCT     = 3;
  localparam longint TIMEOUT_CYCLES = 2_000_000;

  typedef struct {
    logic             command;
    logic [PIX_W-1:0] pixel_value;
  } pix_item_t;

  typedef struct {
    logic [PIX_W-1:0] median_value;
    res_tag_t         tag;
  } median_res_t;

  typedef logic [PIX_W-1:0] column_t [3];

  typedef enum int {PIX_FULL, PIX_EXTREME, PIX_NEAR} pix_mode_e;
  typedef enum int {FRAME_PLAIN, FRAME_NARROW, FRAME_RESIZE} frame_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  mf3_pix_if #(.PIXEL_BITS(PIX_W)) pix ();
  mf3_res_if #(.PIXEL_BITS(PIX_W)) res ();
  mf3_cfg_if                       cfg ();

  median_filter_3x3 #(
    .MAX_WIDTH  (MAX_W),
    .PIXEL_BITS (PIX_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus and expectations
  pix_item_t   pending_pixels[$];
  median_res_t expected_medians[$];

  // predictor state
  logic [PIX_W-1:0] row_two_up [MAX_W];
  logic [PIX_W-1:0] row_one_up [MAX_W];
  column_t          win_cur;
  column_t          win_prev;
  logic [11:0]      col_idx;
  logic [12:0]      row_idx;
  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;

  // bookkeeping
  int          check_errors    = 0;
  int          accepted_items  = 0;
  int          ignored_items   = 0;
  int          medians_checked = 0;
  int          frames_done     = 0;
  int          reg_writes      = 0;
  int          real_items      = 0;
  pix_mode_e   pix_mode        = PIX_FULL;
  logic [PIX_W-1:0] pix_base   = '0;
  logic        noise_on        = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic logic [PIX_W-1:0] median_of_window(column_t l, column_t c, column_t r);
    logic [PIX_W-1:0] v[9];
    logic [PIX_W-1:0] t;
    int i;
    int j;
    for (i = 0; i < 3; i++) begin
      v[i*3+0] = l[i];
      v[i*3+1] = c[i];
      v[i*3+2] = r[i];
    end
    // insertion sort, middle entry is the median
    for (i = 1; i < 9; i++) begin
      t = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > t) begin
        v[j+1] = v[j];
        j--;
      end
      v[j+1] = t;
    end
    return v[4];
  endfunction

  function automatic median_res_t make_median(logic [PIX_W-1:0] val, logic eor, logic eof);
    median_res_t m;
    m.median_value     = val;
    m.tag.last_of_run  = 1'b0;
    m.tag.end_of_row   = eor;
    m.tag.end_of_frame = eof;
    return m;
  endfunction

  function automatic void predict_medians(pix_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    logic        draining;
    logic        end_row;
    logic        is_drain;
    logic [PIX_W-1:0] mid;
    column_t     col;
    median_res_t found[$];
    w = cfg_width;
    h = cfg_height;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (h < 1) h = 1;
    is_drain = (it.command == CMD_DRAIN);
    draining = (row_idx >= h);
    // drain while pixels expected, or pixel while draining: dropped
    if (is_drain != draining) begin
      ignored_items++;
      return;
    end
    x = col_idx;
    if (x > w - 1) x = w - 1;
    end_row = (x == w - 1);
    mid = row_one_up[x];
    col[0] = (row_idx <= 1) ? mid : row_two_up[x];
    col[1] = mid;
    col[2] = is_drain ? mid : it.pixel_value;
    if (!is_drain) begin
      row_two_up[x] = mid;
      row_one_up[x] = it.pixel_value;
    end
    // window shift, left edge replicated
    if (x == 0) begin
      win_cur  = col;
      win_prev = col;
    end else begin
      if (row_idx >= 1)
        found.insert(found.size(),
                     make_median(median_of_window(win_prev, win_cur, col), 1'b0, 1'b0));
      win_prev = win_cur;
      win_cur  = col;
    end
    // right edge replicated on the row's last column
    if (end_row) begin
      if (row_idx >= 1)
        found.insert(found.size(),
                     make_median(median_of_window(win_prev, win_cur, col), 1'b1, draining));
      col_idx = '0;
      row_idx = draining ? '0 : row_idx + 1'b1;
    end else begin
      col_idx = col_idx + 1'b1;
    end
    if (found.size() > 0) found[found.size()-1].tag.last_of_run = 1'b1;
    foreach (found[i]) expected_medians.insert(expected_medians.size(), found[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  pix_item_t driven_item;
  int        burst_left;
  int        gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid       <= 1'b0;
      pix.command     <= CMD_PIXEL;
      pix.pixel_value <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // transfer of the current item
      if (pix.valid && pix.ready) begin
        predict_medians(driven_item);
        accepted_items++;
      end
      // next item, only once the current one is gone
      if (!pix.valid || pix.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix.valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          driven_item = pending_pixels.pop_front();
          pix.valid       <= 1'b1;
          pix.command     <= driven_item.command;
          pix.pixel_value <= driven_item.pixel_value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor with its own stall pattern
  // ---------------------------------------------------------------------------
  median_res_t want;
  int          run_left;
  int          stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
      run_left   = 0;
      stall_left = 0;
    end else begin
      // check each result transfer against the oldest expectation
      if (res.valid && res.ready) begin
        if (expected_medians.size() == 0) begin
          $error("median %0d with nothing expected", res.median_value);
          check_errors++;
        end else begin
          want = expected_medians.pop_front();
          medians_checked++;
          if (res.median_value !== want.median_value) begin
            $error("median_value: expected %0d, actual %0d", want.median_value,
                   res.median_value);
            check_errors++;
          end
          if (res.last_of_run !== want.tag.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.tag.last_of_run,
                   res.last_of_run);
            check_errors++;
          end
          if (res.end_of_row !== want.tag.end_of_row) begin
            $error("end_of_row: expected %0b, actual %0b", want.tag.end_of_row,
                   res.end_of_row);
            check_errors++;
          end
          if (res.end_of_frame !== want.tag.end_of_frame) begin
            $error("end_of_frame: expected %0b, actual %0b", want.tag.end_of_frame,
                   res.end_of_frame);
            check_errors++;
          end
        end
        if (res.end_of_frame === 1'b1) frames_done++;
      end
      // ready pattern: runs of accepts, then short stalls
      if (run_left > 0) begin
        run_left--;
        res.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        run_left   = $urandom_range(1, 30);
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        res.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [PIX_W-1:0] rand_pixel();
    case (pix_mode)
      PIX_FULL: begin
        return PIX_W'($urandom_range(0, 65535));
      end
      PIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return 16'h8000;
          default: return 16'h7FFF;
        endcase
      end
      default: begin
        return PIX_W'(pix_base + $urandom_range(0, 3));
      end
    endcase
  endfunction

  task automatic push_item(logic cmd, logic [PIX_W-1:0] val);
    pix_item_t it;
    it.command     = cmd;
    it.pixel_value = val;
    pending_pixels.insert(pending_pixels.size(), it);
  endtask

  // pixel run, with stray drain commands (noise on) that the block drops
  task automatic send_pixels(int n);
    for (int i = 0; i < n; i++) begin
      if (noise_on && $urandom_range(0, 99) < NOISE_PCT)
        push_item(CMD_DRAIN, PIX_W'($urandom_range(0, 65535)));
      push_item(CMD_PIXEL, rand_pixel());
      real_items++;
    end
  endtask

  // drain run, with stray pixels between drains (noise on) that the block drops
  task automatic send_drains(int n);
    for (int i = 0; i < n; i++) begin
      push_item(CMD_DRAIN, PIX_W'($urandom_range(0, 65535)));
      real_items++;
      if (noise_on && i < n - 1 && $urandom_range(0, 99) < NOISE_PCT)
        push_item(CMD_PIXEL, rand_pixel());
    end
  endtask

  // wait until every item is in and every median is out, then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || pix.valid || expected_medians.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i);
    while (!cfg.ready);
    if (idx == REG_IMAGE_WIDTH) cfg_width = val;
    else                        cfg_height = val;
    reg_writes++;
    cfg.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          w;
    int          h;
    int          h_reg;
    int          r;
    int          p;
    int          w2;
    int          k;
    int          h2;
    int          rem;
    int          random_start;
    frame_kind_e kind;

    for (int i = 0; i < MAX_W; i++) begin
      row_two_up[i] = '0;
      row_one_up[i] = '0;
    end
    win_cur    = '{default: '0};
    win_prev   = '{default: '0};
    col_idx    = '0;
    row_idx    = '0;
    cfg_width  = WIDTH_RST;
    cfg_height = HEIGHT_RST;

    rst_ni    <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_IMAGE_WIDTH;
    cfg.data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 3x2 frame: pixel extremes, drain before any pixel, pixel amid drains
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    @(negedge clk_i);
    push_item(CMD_DRAIN, '1);
    push_item(CMD_PIXEL, '0);
    push_item(CMD_PIXEL, '1);
    push_item(CMD_PIXEL, 16'h8000);
    push_item(CMD_PIXEL, '1);
    push_item(CMD_PIXEL, 16'h0001);
    push_item(CMD_PIXEL, 16'h7FFF);
    push_item(CMD_DRAIN, '0);
    push_item(CMD_PIXEL, 16'h5555);
    push_item(CMD_DRAIN, 16'hAAAA);
    push_item(CMD_DRAIN, '0);
    wait_idle();

    // single-column rows
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    @(negedge clk_i);
    push_item(CMD_PIXEL, 16'h1234);
    push_item(CMD_PIXEL, '1);
    push_item(CMD_PIXEL, '0);
    push_item(CMD_DRAIN, '0);
    wait_idle();

    // width cut below the column count mid-row: next pixel closes the row
    write_reg(REG_IMAGE_WIDTH, 13'd4);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    pix_mode = PIX_FULL;
    @(negedge clk_i);
    send_pixels(7);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 13'd2);
    @(negedge clk_i);
    send_pixels(1);
    send_drains(2);
    wait_idle();

    // oversized width register with height zero, then cut to three columns mid-row
    noise_on = 1'b1;
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    @(negedge clk_i);
    send_pixels(5);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    @(negedge clk_i);
    send_pixels(1);
    send_drains(3);
    wait_idle();

    // zero width register over a short column
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd5);
    @(negedge clk_i);
    send_pixels(5);
    send_drains(1);

    // random frames, some resized mid-frame
    random_start = real_items;
    while (real_items < random_start + RANDOM_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      h_reg = (h == 1 && $urandom_range(0, 1) == 0) ? 0 : h;
      pix_mode = pix_mode_e'($urandom_range(0, 2));
      pix_base = PIX_W'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
        0, 1:    kind = FRAME_NARROW;
        2, 3:    kind = FRAME_RESIZE;
        default: kind = FRAME_PLAIN;
      endcase
      if (kind == FRAME_NARROW && w < 2) kind = FRAME_PLAIN;
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(h_reg));
      @(negedge clk_i);
      case (kind)
        FRAME_NARROW: begin
          // width lowered part way through a row
          r = $urandom_range(0, h - 1);
          p = $urandom_range(1, w - 1);
          send_pixels(r * w + p);
          wait_idle();
          w2 = $urandom_range(1, w - 1);
          write_reg(REG_IMAGE_WIDTH, CFG_W'(w2));
          @(negedge clk_i);
          rem = (p >= w2 - 1) ? 1 : w2 - p;
          send_pixels(rem + (h - r - 1) * w2);
          send_drains(w2);
        end
        FRAME_RESIZE: begin
          // height moved after some full rows, possibly below the rows seen
          k = $urandom_range(1, h);
          send_pixels(k * w);
          wait_idle();
          h2 = $urandom_range(1, h + 3);
          write_reg(REG_IMAGE_HEIGHT, CFG_W'(h2));
          @(negedge clk_i);
          if (h2 > k) send_pixels((h2 - k) * w);
          send_drains(w);
        end
        default: begin
          send_pixels(w * h);
          send_drains(w);
        end
      endcase
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("covered %0d items accepted (%0d dropped by design), %0d medians checked",
             accepted_items, ignored_items, medians_checked);
    $display("%0d frames closed, %0d register writes, zero and oversized registers included",
             frames_done, reg_writes);
    if (check_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("FAIL");
    $finish;
  end

endmodule
